// File: rtl/ehp_pkg.sv
`default_nettype none

package ehp_pkg;

    // Field tags, also used as the parser phase
    localparam logic [4:0] TAG_MAGIC    = 5'd0;
    localparam logic [4:0] TAG_VERSION  = 5'd1;
    localparam logic [4:0] TAG_VARIANT  = 5'd2;
    localparam logic [4:0] TAG_KDF      = 5'd3;
    localparam logic [4:0] TAG_MCOST    = 5'd4;
    localparam logic [4:0] TAG_TCOST    = 5'd5;
    localparam logic [4:0] TAG_PCOST    = 5'd6;
    localparam logic [4:0] TAG_LOGN     = 5'd7;
    localparam logic [4:0] TAG_R        = 5'd8;
    localparam logic [4:0] TAG_P        = 5'd9;
    localparam logic [4:0] TAG_ROUNDS   = 5'd10;
    localparam logic [4:0] TAG_PRF      = 5'd11;
    localparam logic [4:0] TAG_MAC      = 5'd12;
    localparam logic [4:0] TAG_CHUNK    = 5'd13;
    localparam logic [4:0] TAG_SALTLEN  = 5'd14;
    localparam logic [4:0] TAG_SALT     = 5'd15;
    localparam logic [4:0] TAG_TWEAK    = 5'd16;
    localparam logic [4:0] TAG_IV       = 5'd17;
    localparam logic [4:0] TAG_LABELLEN = 5'd18;
    localparam logic [4:0] TAG_LABEL    = 5'd19;
    localparam logic [4:0] PHASE_END    = 5'd20;

    // Key-derivation ids and other accepted codes
    localparam logic [31:0] KDF_ARGON2ID = 32'd1;
    localparam logic [31:0] KDF_SCRYPT   = 32'd2;
    localparam logic [31:0] KDF_PBKDF2   = 32'd3;
    localparam logic [31:0] PRF_ONLY     = 32'd1;
    localparam logic [31:0] VERSION_OLD  = 32'd3;
    localparam logic [31:0] VERSION_NEW  = 32'd4;
    localparam logic [31:0] VARIANT_MAX  = 32'd2;
    localparam logic [31:0] MAC_MIN      = 32'd1;
    localparam logic [31:0] MAC_MAX      = 32'd3;

    // Field lengths in bytes
    localparam logic [15:0] LEN_WORD     = 16'd4;
    localparam logic [15:0] LEN_HALF     = 16'd2;
    localparam logic [15:0] LEN_BYTE     = 16'd1;
    localparam logic [15:0] LEN_TWEAK    = 16'd16;

    // Status codes
    localparam logic [3:0] ST_OK      = 4'd0;
    localparam logic [3:0] ST_TRUNC   = 4'd1;
    localparam logic [3:0] ST_MAGIC   = 4'd2;
    localparam logic [3:0] ST_VERSION = 4'd3;
    localparam logic [3:0] ST_VARIANT = 4'd4;
    localparam logic [3:0] ST_KDF     = 4'd5;
    localparam logic [3:0] ST_PRF     = 4'd6;
    localparam logic [3:0] ST_MAC     = 4'd7;
    localparam logic [3:0] ST_LABEL   = 4'd8;

    // Configuration register indexes
    localparam logic [2:0] CFG_MAGIC_WORD      = 3'd0;
    localparam logic [2:0] CFG_IV_LEN_VARIANT0 = 3'd1;
    localparam logic [2:0] CFG_IV_LEN_VARIANT1 = 3'd2;
    localparam logic [2:0] CFG_IV_LEN_VARIANT2 = 3'd3;
    localparam logic [2:0] CFG_LABEL_LEN_LIMIT = 3'd4;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [4:0]  field_tag;
        logic [7:0]  byte_value;
        logic [15:0] byte_offset;
        logic [31:0] field_value;
        logic        field_complete;
        logic        header_done;
        logic [3:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [31:0] magic_word;
        logic [7:0]  iv_len_variant0;
        logic [7:0]  iv_len_variant1;
        logic [7:0]  iv_len_variant2;
        logic [15:0] label_len_limit;
    } t_cfg;

    typedef struct packed {
        logic [4:0]  field_phase;
        logic [15:0] byte_count;
        logic [31:0] value_accumulator;
        logic        is_version_four;
        logic [1:0]  variant_code;
        logic [7:0]  salt_length;
        logic [15:0] label_length;
    } t_state;

    localparam t_state STATE_RESET = '{
        field_phase:       TAG_MAGIC,
        byte_count:        16'd0,
        value_accumulator: 32'd0,
        is_version_four:   1'b0,
        variant_code:      2'd0,
        salt_length:       8'd0,
        label_length:      16'd0
    };

endpackage

`default_nettype wire

// File: rtl/ehp_cfg_regs.sv
`default_nettype none

module ehp_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    output ehp_pkg::t_cfg      o_cfg
);
    import ehp_pkg::*;

    t_cfg r_cfg;

    // Load the addressed register; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.magic_word      <= 32'd0;
            r_cfg.iv_len_variant0 <= 8'd32;
            r_cfg.iv_len_variant1 <= 8'd64;
            r_cfg.iv_len_variant2 <= 8'd128;
            r_cfg.label_len_limit <= 16'd255;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAGIC_WORD:      r_cfg.magic_word      <= i_cfg_data;
                CFG_IV_LEN_VARIANT0: r_cfg.iv_len_variant0 <= i_cfg_data[7:0];
                CFG_IV_LEN_VARIANT1: r_cfg.iv_len_variant1 <= i_cfg_data[7:0];
                CFG_IV_LEN_VARIANT2: r_cfg.iv_len_variant2 <= i_cfg_data[7:0];
                CFG_LABEL_LEN_LIMIT: r_cfg.label_len_limit <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

// File: rtl/ehp_field_step.sv
`default_nettype none

module ehp_field_step (
    input  ehp_pkg::t_state    i_state,
    input  ehp_pkg::t_in_item  i_item,
    input  ehp_pkg::t_cfg      i_cfg,
    output ehp_pkg::t_out_item o_result,
    output ehp_pkg::t_state    o_next_state
);
    import ehp_pkg::*;

    logic [4:0]  w_phase;
    logic [7:0]  w_iv_len;
    logic [15:0] w_field_len;
    logic        w_numeric;
    logic [31:0] w_acc;
    logic        w_complete;
    logic [4:0]  w_next_phase;
    logic [3:0]  w_status;
    logic [4:0]  w_after_iv;
    logic [4:0]  w_after_tweak;
    t_state      w_updated;

    // Fold any phase past the last field back to the magic
    assign w_phase = (i_state.field_phase > TAG_LABEL) ? TAG_MAGIC : i_state.field_phase;

    // Pick the IV length for the current variant
    always_comb begin
        case (i_state.variant_code)
            2'd0:    w_iv_len = i_cfg.iv_len_variant0;
            2'd1:    w_iv_len = i_cfg.iv_len_variant1;
            default: w_iv_len = i_cfg.iv_len_variant2;
        endcase
    end

    // Field length and numeric class by phase
    always_comb begin
        w_numeric = 1'b1;
        case (w_phase)
            TAG_MAGIC, TAG_MCOST, TAG_TCOST, TAG_PCOST,
            TAG_R, TAG_P, TAG_ROUNDS, TAG_CHUNK: w_field_len = LEN_WORD;
            TAG_LABELLEN: w_field_len = LEN_HALF;
            TAG_SALT: begin
                w_field_len = {8'd0, i_state.salt_length};
                w_numeric   = 1'b0;
            end
            TAG_TWEAK: begin
                w_field_len = LEN_TWEAK;
                w_numeric   = 1'b0;
            end
            TAG_IV: begin
                w_field_len = {8'd0, w_iv_len};
                w_numeric   = 1'b0;
            end
            TAG_LABEL: begin
                w_field_len = i_state.label_length;
                w_numeric   = 1'b0;
            end
            default: w_field_len = LEN_BYTE;
        endcase
    end

    // Shift the byte into the big-endian value of a numeric field; a length already passed completes
    assign w_acc      = w_numeric ? {i_state.value_accumulator[23:0], i_item.in_byte} : 32'd0;
    assign w_complete = ({1'b0, i_state.byte_count} + 17'd1) >= {1'b0, w_field_len};

    assign w_after_iv    = i_state.is_version_four ? TAG_LABELLEN : PHASE_END;
    assign w_after_tweak = (w_iv_len != 8'd0) ? TAG_IV : w_after_iv;

    // Validate the completed field and choose what follows it
    always_comb begin
        w_updated    = i_state;
        w_status     = ST_OK;
        w_next_phase = PHASE_END;
        case (w_phase)
            TAG_MAGIC: begin
                if (w_acc != i_cfg.magic_word) w_status = ST_MAGIC;
                w_next_phase = TAG_VERSION;
            end
            TAG_VERSION: begin
                if (w_acc != VERSION_OLD && w_acc != VERSION_NEW) w_status = ST_VERSION;
                w_updated.is_version_four = (w_acc == VERSION_NEW);
                w_next_phase = TAG_VARIANT;
            end
            TAG_VARIANT: begin
                if (w_acc > VARIANT_MAX) w_status = ST_VARIANT;
                w_updated.variant_code = w_acc[1:0];
                w_next_phase = TAG_KDF;
            end
            TAG_KDF: begin
                if (w_acc == KDF_ARGON2ID) begin
                    w_next_phase = TAG_MCOST;
                end else if (w_acc == KDF_SCRYPT) begin
                    w_next_phase = TAG_LOGN;
                end else if (w_acc == KDF_PBKDF2) begin
                    w_next_phase = TAG_ROUNDS;
                end else begin
                    w_status = ST_KDF;
                end
            end
            TAG_MCOST:  w_next_phase = TAG_TCOST;
            TAG_TCOST:  w_next_phase = TAG_PCOST;
            TAG_PCOST:  w_next_phase = TAG_MAC;
            TAG_LOGN:   w_next_phase = TAG_R;
            TAG_R:      w_next_phase = TAG_P;
            TAG_P:      w_next_phase = TAG_MAC;
            TAG_ROUNDS: w_next_phase = TAG_PRF;
            TAG_PRF: begin
                if (w_acc != PRF_ONLY) w_status = ST_PRF;
                w_next_phase = TAG_MAC;
            end
            TAG_MAC: begin
                if (w_acc < MAC_MIN || w_acc > MAC_MAX) w_status = ST_MAC;
                w_next_phase = TAG_CHUNK;
            end
            TAG_CHUNK: w_next_phase = TAG_SALTLEN;
            TAG_SALTLEN: begin
                w_updated.salt_length = w_acc[7:0];
                w_next_phase = (w_acc[7:0] != 8'd0) ? TAG_SALT : TAG_TWEAK;
            end
            TAG_SALT:  w_next_phase = TAG_TWEAK;
            TAG_TWEAK: w_next_phase = w_after_tweak;
            TAG_IV:    w_next_phase = w_after_iv;
            TAG_LABELLEN: begin
                w_updated.label_length = w_acc[15:0];
                if (w_acc[15:0] > i_cfg.label_len_limit) w_status = ST_LABEL;
                w_next_phase = (w_acc[15:0] != 16'd0) ? TAG_LABEL : PHASE_END;
            end
            default: w_next_phase = PHASE_END;
        endcase
        w_updated.field_phase       = w_next_phase;
        w_updated.byte_count        = 16'd0;
        w_updated.value_accumulator = 32'd0;
    end

    // Build the result and the next state
    always_comb begin
        o_result.field_tag   = w_phase;
        o_result.byte_offset = i_state.byte_count;
        if (i_item.end_of_input) begin
            o_result.byte_value     = 8'd0;
            o_result.field_value    = i_state.value_accumulator;
            o_result.field_complete = 1'b0;
            o_result.header_done    = 1'b1;
            o_result.status         = ST_TRUNC;
            o_next_state            = STATE_RESET;
        end else if (!w_complete) begin
            o_result.byte_value     = i_item.in_byte;
            o_result.field_value    = w_acc;
            o_result.field_complete = 1'b0;
            o_result.header_done    = 1'b0;
            o_result.status         = ST_OK;
            o_next_state                   = i_state;
            o_next_state.field_phase       = w_phase;
            o_next_state.byte_count        = i_state.byte_count + 16'd1;
            o_next_state.value_accumulator = w_acc;
        end else if (w_status != ST_OK || w_next_phase == PHASE_END) begin
            o_result.byte_value     = i_item.in_byte;
            o_result.field_value    = w_acc;
            o_result.field_complete = 1'b1;
            o_result.header_done    = 1'b1;
            o_result.status         = w_status;
            o_next_state            = STATE_RESET;
        end else begin
            o_result.byte_value     = i_item.in_byte;
            o_result.field_value    = w_acc;
            o_result.field_complete = 1'b1;
            o_result.header_done    = 1'b0;
            o_result.status         = ST_OK;
            o_next_state            = w_updated;
        end
    end

endmodule

`default_nettype wire

// File: rtl/encrypted_header_parser.sv
`default_nettype none

// Encrypted-file header parser. Feed header bytes one per request; set
// end_of_input on a request to mark the end of the stream (its byte is ignored).
// Every request yields exactly one result with the field tag, the byte, its
// offset within the field, the big-endian value so far for numeric fields and
// flags for field and header completion; header_done with a nonzero status
// ends a header early on a validation error or truncation, and the parser
// then waits for the next magic. Throughput is one byte per cycle while the
// output is not stalled: the whole field step is a single pass between the
// input register and the result register.
// Configuration registers should be written only while no request is in flight.
module encrypted_header_parser (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_stall,
    input  ehp_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_stall,
    output ehp_pkg::t_out_item o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data
);
    import ehp_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_in_item;
    logic      r_in_valid;
    t_out_item r_out_item;
    logic      r_out_valid;
    t_state    r_state;
    t_state    n_state;
    t_out_item w_res;
    logic      w_adv;
    logic      w_in_take;

    ehp_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    ehp_field_step u_step (
        .i_state      (r_state),
        .i_item       (r_in_item),
        .i_cfg        (w_cfg),
        .o_result     (w_res),
        .o_next_state (n_state)
    );

    // Advance when the result register is empty or being drained
    assign w_adv      = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !w_adv;
    assign w_in_take  = i_in_valid && !o_in_stall;

    // Control: valid flags and parser state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= STATE_RESET;
        end else begin
            if (w_adv || !r_in_valid) begin
                r_in_valid <= i_in_valid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_state <= n_state;
                end
            end
        end
    end

    // Payload: hold the request and the result while stalled
    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_item <= i_in_data;
        end
        if (w_adv && r_in_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

`ifndef NO_ASSERTIONS
    // A finished header leaves the parser at the start of the magic
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && w_res.header_done) |=>
        (r_state.field_phase == TAG_MAGIC && r_state.byte_count == 16'd0))
        else $error("parser did not restart after header end");

    // A partial field advances the byte count by one
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_in_valid && !w_res.field_complete && !w_res.header_done) |=>
        (r_state.byte_count == $past(r_state.byte_count) + 16'd1))
        else $error("byte count did not advance");

    // An error status always ends the header
    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.status == ST_OK || o_out_data.header_done))
        else $error("error status without header end");

    // Stall the input side only while a request is held
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && r_out_valid))
        else $error("input stalled with no request held");
`endif

endmodule

`default_nettype wire
